[hw/rtl/asop_pkg.sv]
// ----------------------------------------------------------------------------
// asop_pkg
// Shared codes, state encoding and control structs of the set-operation block.
// ----------------------------------------------------------------------------
package asop_pkg;

    localparam logic [1:0] CMD_APPEND_A = 2'd0;
    localparam logic [1:0] CMD_APPEND_B = 2'd1;
    localparam logic [1:0] CMD_RUN      = 2'd2;

    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_INTER = 2'd1;
    localparam logic [1:0] OP_DIFF  = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_START  = 8'b0000_0010,
        S_MERGE  = 8'b0000_0100,
        S_TAILA  = 8'b0000_1000,
        S_TAILB  = 8'b0001_0000,
        S_COPY   = 8'b0010_0000,
        S_USCAN  = 8'b0100_0000,
        S_ISCAN  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic inc_i;
        logic inc_j;
        logic clr_i;
        logic clr_j;
        logic emit;
        logic emit_sel_b;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic i_lt_na;
        logic j_lt_nb;
        logic a_lt_b;
        logic a_eq_b;
        logic sorted;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/asop_if.sv]
// ----------------------------------------------------------------------------
// asop_if
// Input and result stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface asop_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface asop_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               last;
    logic               empty_res;
    logic               overflow;

    modport source (output valid, output result_value, output last,
                    output empty_res, output overflow, input ready);
    modport sink   (input valid, input result_value, input last,
                    input empty_res, input overflow, output ready);
endinterface

[hw/rtl/asop_ctrl.sv]
// ----------------------------------------------------------------------------
// asop_ctrl
// Sequencer for appends, merge walk and membership scans; holds the
// operation register.
// ----------------------------------------------------------------------------
module asop_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data,
    input  asop_pkg::t_status i_status,
    output asop_pkg::t_cmd    o_cmd
);
    import asop_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_operation;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_operation <= OP_UNION;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_operation <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_command)
                        CMD_APPEND_A: o_cmd.load_a = 1'b1;
                        CMD_APPEND_B: o_cmd.load_b = 1'b1;
                        CMD_RUN: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_START;
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                if (r_operation != OP_UNION && r_operation != OP_INTER &&
                    r_operation != OP_DIFF) begin
                    n_state = S_IDLE;
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                    end else begin
                        n_state = S_START;
                    end
                end else if (i_status.sorted) begin
                    n_state = S_MERGE;
                end else if (r_operation == OP_UNION) begin
                    n_state = S_COPY;
                end else begin
                    n_state = S_ISCAN;
                end
            end
            S_MERGE: begin
                if (i_status.out_free) begin
                    if (i_status.i_lt_na && i_status.j_lt_nb) begin
                        if (i_status.a_lt_b) begin
                            o_cmd.emit  = (r_operation != OP_INTER);
                            o_cmd.inc_i = 1'b1;
                        end else if (i_status.a_eq_b) begin
                            o_cmd.emit  = (r_operation != OP_DIFF);
                            o_cmd.inc_i = 1'b1;
                            o_cmd.inc_j = 1'b1;
                        end else begin
                            o_cmd.emit       = (r_operation == OP_UNION);
                            o_cmd.emit_sel_b = 1'b1;
                            o_cmd.inc_j      = 1'b1;
                        end
                    end else if (r_operation != OP_INTER) begin
                        n_state = S_TAILA;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_TAILA: begin
                if (i_status.out_free) begin
                    if (i_status.i_lt_na) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.inc_i = 1'b1;
                    end else if (r_operation == OP_UNION) begin
                        n_state = S_TAILB;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_TAILB: begin
                if (i_status.out_free) begin
                    if (i_status.j_lt_nb) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_sel_b = 1'b1;
                        o_cmd.inc_j      = 1'b1;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                if (i_status.out_free) begin
                    if (i_status.i_lt_na) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.inc_i = 1'b1;
                    end else begin
                        o_cmd.clr_i = 1'b1;
                        o_cmd.clr_j = 1'b1;
                        n_state     = S_USCAN;
                    end
                end
            end
            S_USCAN: begin
                // outer walk over second array, inner search of first
                if (i_status.out_free) begin
                    if (!i_status.j_lt_nb) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else if (i_status.i_lt_na) begin
                        if (i_status.a_eq_b) begin
                            o_cmd.inc_j = 1'b1;
                            o_cmd.clr_i = 1'b1;
                        end else begin
                            o_cmd.inc_i = 1'b1;
                        end
                    end else begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_sel_b = 1'b1;
                        o_cmd.inc_j      = 1'b1;
                        o_cmd.clr_i      = 1'b1;
                    end
                end
            end
            S_ISCAN: begin
                // outer walk over first array, inner search of second
                if (i_status.out_free) begin
                    if (!i_status.i_lt_na) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else if (i_status.j_lt_nb) begin
                        if (i_status.a_eq_b) begin
                            o_cmd.emit  = (r_operation == OP_INTER);
                            o_cmd.inc_i = 1'b1;
                            o_cmd.clr_j = 1'b1;
                        end else begin
                            o_cmd.inc_j = 1'b1;
                        end
                    end else begin
                        o_cmd.emit  = (r_operation == OP_DIFF);
                        o_cmd.inc_i = 1'b1;
                        o_cmd.clr_j = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/asop_dp.sv]
// ----------------------------------------------------------------------------
// asop_dp
// Array storage, walk pointers, compare logic, pending and output registers.
// ----------------------------------------------------------------------------
module asop_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  asop_pkg::t_cmd     i_cmd,
    output asop_pkg::t_status  o_status,
    asop_out_if.source         out_ch
);
    import asop_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic signed [31:0] r_a_mem [CAPACITY];
    logic signed [31:0] r_b_mem [CAPACITY];
    logic        [CW-1:0] r_na, r_nb, r_i, r_j;
    logic        [CW-1:0] n_i, n_j;
    logic               r_dropped;
    logic               r_a_sorted, r_b_sorted;
    logic signed [31:0] r_a_last, r_b_last;
    logic               r_pend_valid;
    logic signed [31:0] r_pend;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic               r_out_last, r_out_empty, r_out_ovf;

    logic signed [31:0] r_a_rd, r_b_rd, emit_val;

    always_comb begin
        n_i = r_i;
        if (i_cmd.start || i_cmd.clr_i) begin
            n_i = '0;
        end else if (i_cmd.inc_i) begin
            n_i = r_i + ONE;
        end
        n_j = r_j;
        if (i_cmd.start || i_cmd.clr_j) begin
            n_j = '0;
        end else if (i_cmd.inc_j) begin
            n_j = r_j + ONE;
        end
    end

    assign emit_val = i_cmd.emit_sel_b ? r_b_rd : r_a_rd;

    assign o_status.i_lt_na  = (r_i < r_na);
    assign o_status.j_lt_nb  = (r_j < r_nb);
    assign o_status.a_lt_b   = (r_a_rd < r_b_rd);
    assign o_status.a_eq_b   = (r_a_rd == r_b_rd);
    assign o_status.sorted   = r_a_sorted && r_b_sorted;
    assign o_status.out_free = !r_out_valid || out_ch.ready;

    assign out_ch.valid        = r_out_valid;
    assign out_ch.result_value = r_out_value;
    assign out_ch.last         = r_out_last;
    assign out_ch.empty_res    = r_out_empty;
    assign out_ch.overflow     = r_out_ovf;

    // storage and payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_na < CAP) begin
            r_a_mem[r_na[IW-1:0]] <= i_value;
            r_a_last              <= i_value;
        end
        if (i_cmd.load_b && r_nb < CAP) begin
            r_b_mem[r_nb[IW-1:0]] <= i_value;
            r_b_last              <= i_value;
        end
        // read at the next pointer so the data lines up with r_i and r_j
        r_a_rd <= r_a_mem[n_i[IW-1:0]];
        r_b_rd <= r_b_mem[n_j[IW-1:0]];
        if (i_cmd.emit) begin
            r_pend <= emit_val;
        end
        if (i_cmd.emit && r_pend_valid) begin
            r_out_value <= r_pend;
            r_out_last  <= 1'b0;
            r_out_empty <= 1'b0;
            r_out_ovf   <= r_dropped;
        end else if (i_cmd.finish) begin
            r_out_value <= r_pend_valid ? r_pend : 32'sd0;
            r_out_last  <= 1'b1;
            r_out_empty <= !r_pend_valid;
            r_out_ovf   <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_na         <= '0;
            r_nb         <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_dropped    <= 1'b0;
            r_a_sorted   <= 1'b1;
            r_b_sorted   <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_a) begin
                if (r_na < CAP) begin
                    r_na <= r_na + ONE;
                    if (r_na != '0 && i_value < r_a_last) begin
                        r_a_sorted <= 1'b0;
                    end
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.load_b) begin
                if (r_nb < CAP) begin
                    r_nb <= r_nb + ONE;
                    if (r_nb != '0 && i_value < r_b_last) begin
                        r_b_sorted <= 1'b0;
                    end
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            r_i <= n_i;
            r_j <= n_j;

            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end

            if ((i_cmd.emit && r_pend_valid) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_na       <= '0;
                r_nb       <= '0;
                r_dropped  <= 1'b0;
                r_a_sorted <= 1'b1;
                r_b_sorted <= 1'b1;
            end
        end
    end

endmodule

[hw/rtl/array_set_operations.sv]
// ----------------------------------------------------------------------------
// array_set_operations
// Union, intersection or difference of two loaded integer arrays.
// ----------------------------------------------------------------------------
// Appends are taken one per cycle. A run walks the stored arrays one step
// per cycle: the sorted merge walks both arrays side by side, the membership
// scans search one array for each element of the other, all with the single
// compare unit stepping the two array pointers; a closing step ends the run.
// Results leave through an output register, each step waits while that
// register is full, and no new item is taken until the run is closed.
module array_set_operations #(
    parameter int CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asop_in_if.sink    in_ch,
    asop_out_if.source out_ch,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);
    import asop_pkg::*;

    t_cmd    cmd;
    t_status status;

    asop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_command   (in_ch.command),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    asop_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (in_ch.value),
        .i_cmd    (cmd),
        .o_status (status),
        .out_ch   (out_ch)
    );

endmodule
